>>> sv/smp_pkg.sv
// Package for the STUN message parser: result codes, queue sizing and the
// result record type. No dependencies.
package smp_pkg;

   // Fixed sizes of the message layout.
   localparam int HDR_BYTES     = 20;
   localparam int ATTR_HDR      = 4;
   localparam int VALUE_KEEP    = 8;
   localparam int COUNT_W       = 17;
   localparam logic [15:0] MAX_ATTR_TYPE = 16'h7fff;

   // Result queue sizing.
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_ADDRESS = 2'd0,
      KIND_UNKNOWN = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_SHORT = 2'd1,
      STATUS_MISMATCH  = 2'd2,
      STATUS_OVERRUN   = 2'd3
   } status_type;

   // Attribute type codes that carry an address value.
   localparam logic [15:0] ATTR_MAPPED_ADDRESS   = 16'h0001;
   localparam logic [15:0] ATTR_RESPONSE_ADDRESS = 16'h0002;
   localparam logic [15:0] ATTR_SOURCE_ADDRESS   = 16'h0004;
   localparam logic [15:0] ATTR_CHANGED_ADDRESS  = 16'h0005;
   localparam logic [15:0] ATTR_REFLECTED_FROM   = 16'h000b;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] attribute_type;
      logic [7:0]  family;
      logic [15:0] port;
      logic [31:0] ip_address;
      logic [15:0] message_type;
      logic [15:0] message_length;
      logic [63:0] tid_upper;
      logic [63:0] tid_lower;
      status_type  status;
      logic        final_res;
   } result_type;

endpackage

>>> sv/smp_req_if.sv
// Request channel of the STUN message parser: one message byte per request.
// No dependencies.
interface smp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

>>> sv/smp_rsp_if.sv
// Result channel of the STUN message parser: attribute and summary results.
// No dependencies.
interface smp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] attribute_type;
   logic [7:0]  family;
   logic [15:0] port;
   logic [31:0] ip_address;
   logic [15:0] message_type;
   logic [15:0] message_length;
   logic [63:0] tid_upper;
   logic [63:0] tid_lower;
   logic [1:0]  status;
   logic        final_res;

   modport source (output valid, output kind, output attribute_type, output family,
                   output port, output ip_address, output message_type,
                   output message_length, output tid_upper, output tid_lower,
                   output status, output final_res, input ready);
   modport sink   (input valid, input kind, input attribute_type, input family,
                   input port, input ip_address, input message_type,
                   input message_length, input tid_upper, input tid_lower,
                   input status, input final_res, output ready);
endinterface

>>> sv/stun_message_parser_core.sv
// A result is written into the result queue when the request byte that causes it is accepted.
// Throughput: one byte per cycle; a byte produces zero, one or two results, which
// go to a four-entry result queue, and the byte request is held off while the
// queue holds more than two results. The header and attribute walk registers are
// updated by a single pass of logic per byte. Synchronous reset clears the parse
// state and empties the queue; the parse state also clears after every last byte.
module stun_message_parser_core (
   input logic     clock,
   input logic     reset,
   smp_req_if.sink   req_if,
   smp_rsp_if.source rsp_if
);

   localparam logic [smp_pkg::COUNT_W-1:0] COUNT_MAX = '1;

   // Parse state.
   logic [smp_pkg::COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [15:0] header_type_ff, header_type_in;
   logic [15:0] header_length_ff, header_length_in;
   logic [63:0] tid_upper_ff, tid_upper_in;
   logic [63:0] tid_lower_ff, tid_lower_in;
   logic [15:0] attr_type_ff, attr_type_in;
   logic [15:0] attr_length_ff, attr_length_in;
   logic [smp_pkg::COUNT_W-1:0] attr_pos_ff, attr_pos_in;
   logic [63:0] value_ff, value_in;
   logic        overrun_ff, overrun_in;

   // Result queue.
   smp_pkg::result_type       queue_ff [smp_pkg::QUEUE_DEPTH];
   logic [smp_pkg::PTR_W-1:0] head_ff, head_in;
   logic [smp_pkg::PTR_W-1:0] tail_ff, tail_in;
   logic [smp_pkg::CNT_W-1:0] count_ff, count_in;

   logic                req_fire;
   logic                rsp_fire;
   logic                attr_valid;
   logic                summ_valid;
   smp_pkg::result_type attr_res;
   smp_pkg::result_type summ_res;
   smp_pkg::result_type first_res;
   logic [1:0]          push_count;

   function automatic logic is_address_type(input logic [15:0] t);
      return t == smp_pkg::ATTR_MAPPED_ADDRESS   || t == smp_pkg::ATTR_RESPONSE_ADDRESS ||
             t == smp_pkg::ATTR_SOURCE_ADDRESS   || t == smp_pkg::ATTR_CHANGED_ADDRESS  ||
             t == smp_pkg::ATTR_REFLECTED_FROM;
   endfunction

   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_fire     = rsp_if.valid && rsp_if.ready;
   assign req_if.ready = count_ff <= smp_pkg::CNT_W'(smp_pkg::QUEUE_DEPTH - 2);

   // Per-byte parse: header capture, attribute walk and summary.
   always_comb begin
      logic [smp_pkg::COUNT_W-1:0] c;
      logic [7:0]  b;
      logic [smp_pkg::COUNT_W-1:0] body_end;
      logic [15:0] off;
      logic [15:0] len_full;
      logic [17:0] extent;
      logic [2:0]  tid_idx;
      logic        finish;
      logic [15:0] fin_type;
      logic [15:0] fin_len;
      logic [63:0] fin_value;
      logic [2:0]  fill_bytes;

      c          = byte_count_ff;
      b          = req_if.data_byte;
      body_end   = smp_pkg::COUNT_W'(smp_pkg::HDR_BYTES) + {1'b0, header_length_ff};
      off        = 16'(c - smp_pkg::COUNT_W'(smp_pkg::HDR_BYTES));
      len_full   = {attr_length_ff[15:8], b};
      extent     = {2'b00, off} + {2'b00, len_full} + 18'd1;
      tid_idx    = 3'd3 - c[2:0];
      finish     = 1'b0;
      fin_type   = attr_type_ff;
      fin_len    = '0;
      fin_value  = '0;
      fill_bytes = '0;

      byte_count_in    = byte_count_ff;
      header_type_in   = header_type_ff;
      header_length_in = header_length_ff;
      tid_upper_in     = tid_upper_ff;
      tid_lower_in     = tid_lower_ff;
      attr_type_in     = attr_type_ff;
      attr_length_in   = attr_length_ff;
      attr_pos_in      = attr_pos_ff;
      value_in         = value_ff;
      overrun_in       = overrun_ff;
      attr_valid       = 1'b0;
      summ_valid       = 1'b0;
      attr_res         = '0;
      summ_res         = '0;

      if (req_fire) begin
         // Header bytes land at their fixed positions.
         if (c < smp_pkg::COUNT_W'(2)) begin
            if (c[0]) header_type_in[7:0] = b;
            else      header_type_in[15:8] = b;
         end else if (c < smp_pkg::COUNT_W'(4)) begin
            if (c[0]) header_length_in[7:0] = b;
            else      header_length_in[15:8] = b;
         end else if (c < smp_pkg::COUNT_W'(12)) begin
            tid_upper_in[{tid_idx, 3'b000} +: 8] = b;
         end else if (c < smp_pkg::COUNT_W'(smp_pkg::HDR_BYTES)) begin
            tid_lower_in[{tid_idx, 3'b000} +: 8] = b;
         end else if (c < body_end && !overrun_ff) begin
            // Attribute walk over the body.
            if (attr_pos_ff == smp_pkg::COUNT_W'(0)) begin
               if ((header_length_ff - off) >= 16'(smp_pkg::ATTR_HDR)) begin
                  attr_type_in = {b, 8'h00};
                  attr_pos_in  = smp_pkg::COUNT_W'(1);
               end
            end else if (attr_pos_ff == smp_pkg::COUNT_W'(1)) begin
               attr_type_in = {attr_type_ff[15:8], b};
               attr_pos_in  = smp_pkg::COUNT_W'(2);
            end else if (attr_pos_ff == smp_pkg::COUNT_W'(2)) begin
               attr_length_in = {b, 8'h00};
               attr_pos_in    = smp_pkg::COUNT_W'(3);
            end else if (attr_pos_ff == smp_pkg::COUNT_W'(3)) begin
               attr_length_in = len_full;
               if (extent > {2'b00, header_length_ff}) begin
                  // Attribute reaches past the body: stop the walk.
                  overrun_in  = 1'b1;
                  attr_pos_in = '0;
               end else begin
                  value_in = '0;
                  if (len_full == 16'd0) begin
                     finish = 1'b1;
                  end else begin
                     attr_pos_in = smp_pkg::COUNT_W'(4);
                  end
               end
            end else begin
               // Value byte; only the first eight are kept.
               if (attr_pos_ff < smp_pkg::COUNT_W'(smp_pkg::ATTR_HDR + smp_pkg::VALUE_KEEP)) begin
                  value_in = {value_ff[55:0], b};
               end
               attr_pos_in = attr_pos_ff + smp_pkg::COUNT_W'(1);
               if ((attr_pos_ff - smp_pkg::COUNT_W'(3)) >= {1'b0, attr_length_ff}) begin
                  finish = 1'b1;
               end
            end
         end

         // Emit a finished attribute and clear the walk registers.
         if (finish) begin
            fin_type  = attr_type_in;
            fin_len   = attr_length_in;
            fin_value = value_in;
            if (fin_len == 16'd0) begin
               fin_value = '0;
            end else if (fin_len < 16'(smp_pkg::VALUE_KEEP)) begin
               // A short value is left-aligned with zeros after it.
               fill_bytes = 3'd0 - fin_len[2:0];
               fin_value  = fin_value << {fill_bytes, 3'b000};
            end
            if (is_address_type(fin_type)) begin
               attr_valid              = 1'b1;
               attr_res.kind           = smp_pkg::KIND_ADDRESS;
               attr_res.attribute_type = fin_type;
               attr_res.family         = fin_value[55:48];
               attr_res.port           = fin_value[47:32];
               attr_res.ip_address     = fin_value[31:0];
            end else if (fin_type <= smp_pkg::MAX_ATTR_TYPE) begin
               attr_valid              = 1'b1;
               attr_res.kind           = smp_pkg::KIND_UNKNOWN;
               attr_res.attribute_type = fin_type;
            end
            attr_pos_in    = '0;
            attr_type_in   = '0;
            attr_length_in = '0;
            value_in       = '0;
         end

         // Saturating byte count.
         if (byte_count_ff != COUNT_MAX) begin
            byte_count_in = byte_count_ff + smp_pkg::COUNT_W'(1);
         end

         // Summary on the last byte, then start over.
         if (req_if.end_of_message) begin
            summ_valid              = 1'b1;
            summ_res.kind           = smp_pkg::KIND_SUMMARY;
            summ_res.message_type   = header_type_in;
            summ_res.message_length = header_length_in;
            summ_res.tid_upper      = tid_upper_in;
            summ_res.tid_lower      = tid_lower_in;
            summ_res.final_res      = 1'b1;
            if (byte_count_in < smp_pkg::COUNT_W'(smp_pkg::HDR_BYTES)) begin
               summ_res.status = smp_pkg::STATUS_TOO_SHORT;
            end else if (byte_count_in != smp_pkg::COUNT_W'(smp_pkg::HDR_BYTES) +
                                          {1'b0, header_length_in}) begin
               summ_res.status = smp_pkg::STATUS_MISMATCH;
            end else if (overrun_in) begin
               summ_res.status = smp_pkg::STATUS_OVERRUN;
            end else begin
               summ_res.status = smp_pkg::STATUS_OK;
            end
            byte_count_in    = '0;
            header_type_in   = '0;
            header_length_in = '0;
            tid_upper_in     = '0;
            tid_lower_in     = '0;
            attr_type_in     = '0;
            attr_length_in   = '0;
            attr_pos_in      = '0;
            value_in         = '0;
            overrun_in       = 1'b0;
         end
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff    <= '0;
         header_type_ff   <= '0;
         header_length_ff <= '0;
         tid_upper_ff     <= '0;
         tid_lower_ff     <= '0;
         attr_type_ff     <= '0;
         attr_length_ff   <= '0;
         attr_pos_ff      <= '0;
         value_ff         <= '0;
         overrun_ff       <= 1'b0;
      end else begin
         byte_count_ff    <= byte_count_in;
         header_type_ff   <= header_type_in;
         header_length_ff <= header_length_in;
         tid_upper_ff     <= tid_upper_in;
         tid_lower_ff     <= tid_lower_in;
         attr_type_ff     <= attr_type_in;
         attr_length_ff   <= attr_length_in;
         attr_pos_ff      <= attr_pos_in;
         value_ff         <= value_in;
         overrun_ff       <= overrun_in;
      end
   end

   // The attribute result goes ahead of the summary from the same byte.
   assign first_res  = attr_valid ? attr_res : summ_res;
   assign push_count = {1'b0, attr_valid} + {1'b0, summ_valid};

   // Queue pointers.
   always_comb begin
      tail_in  = tail_ff + smp_pkg::PTR_W'(push_count);
      head_in  = rsp_fire ? head_ff + smp_pkg::PTR_W'(1) : head_ff;
      count_in = count_ff + smp_pkg::CNT_W'(push_count) - smp_pkg::CNT_W'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_ff[tail_ff] <= first_res;
      end
      if (push_count == 2'd2) begin
         queue_ff[tail_ff + smp_pkg::PTR_W'(1)] <= summ_res;
      end
   end

   // Result channel.
   assign rsp_if.valid          = count_ff != '0;
   assign rsp_if.kind           = queue_ff[head_ff].kind;
   assign rsp_if.attribute_type = queue_ff[head_ff].attribute_type;
   assign rsp_if.family         = queue_ff[head_ff].family;
   assign rsp_if.port           = queue_ff[head_ff].port;
   assign rsp_if.ip_address     = queue_ff[head_ff].ip_address;
   assign rsp_if.message_type   = queue_ff[head_ff].message_type;
   assign rsp_if.message_length = queue_ff[head_ff].message_length;
   assign rsp_if.tid_upper      = queue_ff[head_ff].tid_upper;
   assign rsp_if.tid_lower      = queue_ff[head_ff].tid_lower;
   assign rsp_if.status         = queue_ff[head_ff].status;
   assign rsp_if.final_res      = queue_ff[head_ff].final_res;

   // The queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= smp_pkg::CNT_W'(smp_pkg::QUEUE_DEPTH))
      else $error("result queue over its depth");

   // A last byte always leaves a summary waiting in the queue.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_if.end_of_message |=> count_ff != '0)
      else $error("last byte left no result queued");

   // The parse state starts over after a last byte.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_if.end_of_message |=> byte_count_ff == '0 && !overrun_ff)
      else $error("parse state not cleared after last byte");

endmodule
